// ===== sv/glc_pkg.sv =====
`timescale 1ns / 1ps

package glc_pkg;

   // Fixed field widths of the point and result items.
   localparam int ID_W       = 32;
   localparam int SLOT_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int RADIUS_W   = 37;
   localparam int MASK_W     = 8;
   localparam int PORT_DIMS  = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 37;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS_LIMIT = 1'b0,
      CSR_DIM_MASK     = 1'b1
   } csr_index_type;

   localparam logic [MASK_W-1:0] DIM_MASK_RESET = 8'hFF;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== sv/glc_ram.sv =====
`timescale 1ns / 1ps

module glc_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_enable,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/greedy_leader_clustering_unit.sv =====
`timescale 1ns / 1ps

// Greedy leader clustering unit.
// A point item is accepted on a rising edge where start is high and busy is low.
// The unit then walks its center table in slot order, one center per cycle with
// all dimensions squared in parallel, and stops at the first center whose squared
// distance over the enabled dimensions is at or below radius_limit. An uncovered
// point is appended as a new center, or flagged as table_full when no slot is free.
// One result item is shown for exactly one cycle with rsp_valid high; the receiver
// cannot stall it, so it must take it on that cycle.
// A hit is answered once its center has passed the memory read register, square
// register and sum/compare; a miss, once all stored centers have drained from
// that pipeline. The walk is set by the single read port of the center memory.
// busy stays high until the result shows, so the next item can be accepted in
// the cycle the result is presented. Configuration (radius_limit at index 0,
// dim_mask at index 1) must be written through the csr port only while busy is
// low; the unit does not enforce this. Reset empties the table, sets radius_limit
// to 0 and dim_mask to all ones; the center memory itself is not cleared, since
// only slots below the stored count are ever read.

module greedy_leader_clustering_unit #(
   parameter int DIMS        = 8,
   parameter int MAX_CENTERS = 256,
   parameter int COORD_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [glc_pkg::ID_W-1:0]             req_point_id,
   input  logic                                 req_block_start,
   input  logic signed [COORD_BITS-1:0]         req_coord_0,
   input  logic signed [COORD_BITS-1:0]         req_coord_1,
   input  logic signed [COORD_BITS-1:0]         req_coord_2,
   input  logic signed [COORD_BITS-1:0]         req_coord_3,
   input  logic signed [COORD_BITS-1:0]         req_coord_4,
   input  logic signed [COORD_BITS-1:0]         req_coord_5,
   input  logic signed [COORD_BITS-1:0]         req_coord_6,
   input  logic signed [COORD_BITS-1:0]         req_coord_7,
   output logic                                 rsp_valid,
   output logic                                 rsp_covered,
   output logic [glc_pkg::SLOT_W-1:0]           rsp_slot,
   output logic                                 rsp_added,
   output logic                                 rsp_table_full,
   output logic [glc_pkg::COUNT_W-1:0]          rsp_center_count,
   input  logic                                 csr_write_enable,
   input  logic [glc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [glc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import glc_pkg::*;

   localparam int IDX_W   = $clog2(MAX_CENTERS);
   localparam int CNT_W   = $clog2(MAX_CENTERS + 1);
   localparam int CRD_W   = DIMS * COORD_BITS;
   localparam int WORD_W  = ID_W + CRD_W;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int SUM_W   = SQ_W + 3;
   localparam int CMP_W   = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

   // Configuration registers.
   logic [RADIUS_W-1:0] radius_ff;
   logic [MASK_W-1:0]   mask_ff;

   // Sequencer and table state.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;

   // Point under test.
   logic signed [COORD_BITS-1:0] pt_coord_ff [DIMS];
   logic [ID_W-1:0]              pt_id_ff;
   logic signed [COORD_BITS-1:0] coord_in [PORT_DIMS];

   // Compare pipeline: memory read stage, square stage, sum and compare.
   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [SQ_W-1:0]     sq_ff [DIMS];
   logic [SQ_W-1:0]     sq_in [DIMS];
   logic [SUM_W-1:0]    dist_sum;

   // Result registers.
   logic                rsp_valid_ff;
   logic                rsp_covered_ff, rsp_added_ff, rsp_full_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // Control.
   logic                accept;
   logic                pending;
   logic                issue_go;
   logic                hit;
   logic                drained;
   logic                finish;
   logic                append;
   logic                table_full;

   // Memory ports.
   logic [WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]   wr_word;
   logic [CRD_W-1:0]    wr_coords;

   always_comb begin
      coord_in[0] = req_coord_0;
      coord_in[1] = req_coord_1;
      coord_in[2] = req_coord_2;
      coord_in[3] = req_coord_3;
      coord_in[4] = req_coord_4;
      coord_in[5] = req_coord_5;
      coord_in[6] = req_coord_6;
      coord_in[7] = req_coord_7;
   end

   assign accept = start && !busy;

   // The table walk reads one center per cycle through the registered RAM port.
   glc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_CENTERS)
   ) u_centers (
      .clock     (clock),
      .wr_enable (append),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (wr_word),
      .rd_addr   (issue_ff[IDX_W-1:0]),
      .rd_data   (rd_word)
   );

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         wr_coords[d*COORD_BITS +: COORD_BITS] = pt_coord_ff[d];
      end
      // The point id is kept with its center for a later read-out path.
      wr_word = {pt_id_ff, wr_coords};
   end

   // Square stage: one signed difference and one square per dimension.
   always_comb begin
      logic signed [DIFF_W-1:0]   diff;
      logic signed [2*DIFF_W-1:0] prod;
      logic signed [COORD_BITS-1:0] ctr;
      for (int d = 0; d < DIMS; d++) begin
         ctr  = rd_word[d*COORD_BITS +: COORD_BITS];
         diff = DIFF_W'(pt_coord_ff[d]) - DIFF_W'(ctr);
         prod = diff * diff;
         sq_in[d] = mask_ff[d] ? prod[SQ_W-1:0] : '0;
      end
   end

   // Sum and compare stage.
   always_comb begin
      dist_sum = '0;
      for (int d = 0; d < DIMS; d++) begin
         dist_sum = dist_sum + SUM_W'(sq_ff[d]);
      end
   end

   assign hit        = s2_valid_ff && (CMP_W'(dist_sum) <= CMP_W'(radius_ff));
   assign pending    = issue_ff < count_ff;
   assign drained    = !pending && !s1_valid_ff && !s2_valid_ff;
   assign table_full = count_ff == CNT_W'(MAX_CENTERS);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy     = 1'b0;
      finish   = 1'b0;
      issue_go = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SCAN: begin
            busy     = 1'b1;
            finish   = hit || drained;
            issue_go = !finish && pending;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign append = finish && !hit && !table_full;

   always_comb begin
      issue_in    = issue_ff;
      count_in    = count_ff;
      s1_valid_in = issue_go;
      s2_valid_in = s1_valid_ff && !finish;
      if (accept) begin
         issue_in = '0;
         // A block start empties the table before its own point is handled.
         if (req_block_start) begin
            count_in = '0;
         end
      end else if (issue_go) begin
         issue_in = issue_ff + 1'b1;
      end
      if (append) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (hit) begin
         rsp_slot_in = SLOT_W'(s2_idx_ff);
      end else if (!table_full) begin
         rsp_slot_in = SLOT_W'(count_ff[IDX_W-1:0]);
      end else begin
         rsp_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= '0;
         mask_ff      <= DIM_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= finish;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_RADIUS_LIMIT: radius_ff <= csr_write_data[RADIUS_W-1:0];
               CSR_DIM_MASK:     mask_ff   <= csr_write_data[MASK_W-1:0];
               default: begin
                  radius_ff <= radius_ff;
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pt_id_ff <= req_point_id;
         for (int d = 0; d < DIMS; d++) begin
            pt_coord_ff[d] <= coord_in[d];
         end
      end
      s1_idx_ff <= issue_ff[IDX_W-1:0];
      s2_idx_ff <= s1_idx_ff;
      for (int d = 0; d < DIMS; d++) begin
         sq_ff[d] <= sq_in[d];
      end
      if (finish) begin
         rsp_covered_ff <= hit;
         rsp_added_ff   <= append;
         rsp_full_ff    <= !hit && table_full;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_count_ff   <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_covered      = rsp_covered_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_added        = rsp_added_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_center_count = rsp_count_ff;

endmodule

// ===== sv/glc_checker.sv =====
`timescale 1ns / 1ps

module glc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_covered,
   input logic rsp_added,
   input logic rsp_table_full
);

   // An accepted item always keeps the unit busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the unit busy");

   // The unit only goes idle by delivering the result of its item.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("unit went idle without a result");

   // One item yields one result, so results never come on adjacent cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Each result is exactly one of covered, added or dropped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_covered, rsp_added, rsp_table_full}))
      else $error("result outcome flags are not exclusive");

endmodule

bind greedy_leader_clustering_unit glc_checker u_glc_checker (.*);
